FILE: src/ptc_pkg.sv
`timescale 1ns / 1ps

package ptc_pkg;

    // Port field widths
    localparam int SIDE_W = 14;
    localparam int MED_W  = 14;
    localparam int AREA_W = 27;

    // Defaults for the top level parameters
    localparam int SIDE_BITS_DEF  = 14;
    localparam int SQRT_STEPS_DEF = 2;

    typedef struct packed {
        logic [SIDE_W-1:0] side_a;
        logic [SIDE_W-1:0] side_b;
        logic [SIDE_W-1:0] side_c;
    } sides_t;

    typedef struct packed {
        logic              perfect;
        logic              medians_integral;
        logic              area_integral;
        logic [AREA_W-1:0] area;
        logic [MED_W-1:0]  median_a;
        logic [MED_W-1:0]  median_b;
        logic [MED_W-1:0]  median_c;
    } result_t;

endpackage

FILE: src/ptc_sqrt.sv
`timescale 1ns / 1ps

// Pipelined digit-by-digit integer square root, STEPS root bits per stage.
module ptc_sqrt
    import ptc_pkg::*;
#(
    parameter int ROOT_W = 27,
    parameter int STEPS  = SQRT_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   rad,
    output logic [ROOT_W-1:0]     root,
    output logic                  exact
);

    localparam int NSTG   = (ROOT_W + STEPS - 1) / STEPS;
    localparam int PAD_W  = NSTG * STEPS;
    localparam int RADP_W = 2 * PAD_W;
    localparam int REM_W  = PAD_W + 2;

    logic [RADP_W-1:0] rad_reg  [NSTG];
    logic [REM_W-1:0]  rem_reg  [NSTG];
    logic [PAD_W-1:0]  root_reg [NSTG];

    genvar s;
    generate
        for (s = 0; s < NSTG; s++) begin : g_stg
            logic [RADP_W-1:0] rad_in;
            logic [REM_W-1:0]  rem_in;
            logic [PAD_W-1:0]  root_in;
            logic [RADP_W-1:0] rad_next;
            logic [REM_W-1:0]  rem_next;
            logic [PAD_W-1:0]  root_next;

            if (s == 0) begin : g_first
                assign rad_in  = RADP_W'(rad);
                assign rem_in  = '0;
                assign root_in = '0;
            end
            else begin : g_rest
                assign rad_in  = rad_reg[s-1];
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
            end

            always_comb
            begin
                logic [REM_W-1:0] trial;
                rad_next  = rad_in;
                rem_next  = rem_in;
                root_next = root_in;
                for (int j = 0; j < STEPS; j++) begin
                    // bring down the next pair of radicand bits
                    rem_next = {rem_next[REM_W-3:0], rad_next[RADP_W-1 -: 2]};
                    rad_next = rad_next << 2;
                    trial    = {root_next, 2'b01};
                    if (rem_next >= trial) begin
                        rem_next  = rem_next - trial;
                        root_next = {root_next[PAD_W-2:0], 1'b1};
                    end
                    else begin
                        root_next = {root_next[PAD_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en) begin
                    rad_reg[s]  <= rad_next;
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                end
            end
        end
    endgenerate

    assign root  = root_reg[NSTG-1][ROOT_W-1:0];
    assign exact = (rem_reg[NSTG-1] == '0);

endmodule

FILE: src/perfect_triangle_check_unit.sv
`timescale 1ns / 1ps

// Throughput: one item per cycle; the whole pipeline holds while the result is stalled.
// The rate is set by the shared pipeline enable; the root units take SQRT_STEPS bits a stage.
// Reset: asynchronous, active low; clears every valid bit, payload registers are not reset.
module perfect_triangle_check_unit
    import ptc_pkg::*;
#(
    parameter int SIDE_BITS  = SIDE_BITS_DEF,
    parameter int SQRT_STEPS = SQRT_STEPS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sides_valid,
    output logic    sides_stall,
    input  sides_t  sides,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int N       = SIDE_BITS;
    localparam int SQ_W    = 2 * N;          // side squared
    localparam int DISC_W  = 2 * N + 4;      // signed median discriminant
    localparam int MQ_W    = 2 * N;          // discriminant over four
    localparam int P_W     = N + 2;          // perimeter
    localparam int F_W     = N + 1;          // positive Heron factor
    localparam int FS_W    = N + 2;          // signed Heron factor
    localparam int PF_W    = P_W + F_W;
    localparam int FF_W    = 2 * F_W;
    localparam int H       = F_W;            // split point of the second product
    localparam int PL_W    = PF_W + H;
    localparam int S16_W   = PF_W + FF_W;
    localparam int ROOT_W  = 2 * N - 1;      // area root width
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int NSTG    = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
    localparam int LAT     = 5 + NSTG;

    // One enable for the whole pipeline: advance unless the result waits and is stalled
    logic en;
    logic [LAT-1:0] valid_reg;

    assign en          = !(valid_reg[LAT-1] && result_stall);
    assign sides_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], sides_valid};
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: squares, perimeter and signed Heron factors
    // ---------------------------------------------------------------
    logic [N-1:0] a, b, c;
    assign a = sides.side_a[N-1:0];
    assign b = sides.side_b[N-1:0];
    assign c = sides.side_c[N-1:0];

    logic [SQ_W-1:0] sq_a_reg, sq_b_reg, sq_c_reg;
    logic [P_W-1:0]  p_reg;
    logic [FS_W-1:0] f1_reg, f2_reg, f3_reg;

    always_ff @(posedge clk)
    begin
        if (en) begin
            sq_a_reg <= SQ_W'(a) * SQ_W'(a);
            sq_b_reg <= SQ_W'(b) * SQ_W'(b);
            sq_c_reg <= SQ_W'(c) * SQ_W'(c);
            p_reg    <= P_W'(a) + P_W'(b) + P_W'(c);
            f1_reg   <= FS_W'(b) + FS_W'(c) - FS_W'(a);
            f2_reg   <= FS_W'(a) + FS_W'(c) - FS_W'(b);
            f3_reg   <= FS_W'(a) + FS_W'(b) - FS_W'(c);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: discriminants and their checks; first Heron products
    // ---------------------------------------------------------------
    logic [DISC_W-1:0] da, db, dc;
    assign da = (DISC_W'(sq_b_reg) << 1) + (DISC_W'(sq_c_reg) << 1) - DISC_W'(sq_a_reg);
    assign db = (DISC_W'(sq_a_reg) << 1) + (DISC_W'(sq_c_reg) << 1) - DISC_W'(sq_b_reg);
    assign dc = (DISC_W'(sq_a_reg) << 1) + (DISC_W'(sq_b_reg) << 1) - DISC_W'(sq_c_reg);

    // A median check passes only for a positive discriminant divisible by four
    logic [2:0] mok;
    assign mok[0] = !da[DISC_W-1] && (da != '0) && (da[1:0] == 2'b00);
    assign mok[1] = !db[DISC_W-1] && (db != '0) && (db[1:0] == 2'b00);
    assign mok[2] = !dc[DISC_W-1] && (dc != '0) && (dc[1:0] == 2'b00);

    // All three factors positive means a real triangle; the perimeter follows
    logic hok;
    assign hok = !f1_reg[FS_W-1] && (f1_reg != '0)
              && !f2_reg[FS_W-1] && (f2_reg != '0)
              && !f3_reg[FS_W-1] && (f3_reg != '0);

    logic [MQ_W-1:0] mq_a_s2_reg, mq_b_s2_reg, mq_c_s2_reg;
    logic [2:0]      mok_s2_reg;
    logic            hok_s2_reg;
    logic [PF_W-1:0] pf_reg;
    logic [FF_W-1:0] ff_reg;

    always_ff @(posedge clk)
    begin
        if (en) begin
            mq_a_s2_reg <= da[MQ_W+1:2];
            mq_b_s2_reg <= db[MQ_W+1:2];
            mq_c_s2_reg <= dc[MQ_W+1:2];
            mok_s2_reg  <= mok;
            hok_s2_reg  <= hok;
            pf_reg      <= PF_W'(p_reg) * PF_W'(f1_reg[F_W-1:0]);
            ff_reg      <= FF_W'(f2_reg[F_W-1:0]) * FF_W'(f3_reg[F_W-1:0]);
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: wide product split into two partial products
    // ---------------------------------------------------------------
    logic [MQ_W-1:0] mq_a_s3_reg, mq_b_s3_reg, mq_c_s3_reg;
    logic [2:0]      mok_s3_reg;
    logic            hok_s3_reg;
    logic [PL_W-1:0] plo_reg, phi_reg;

    always_ff @(posedge clk)
    begin
        if (en) begin
            mq_a_s3_reg <= mq_a_s2_reg;
            mq_b_s3_reg <= mq_b_s2_reg;
            mq_c_s3_reg <= mq_c_s2_reg;
            mok_s3_reg  <= mok_s2_reg;
            hok_s3_reg  <= hok_s2_reg;
            plo_reg     <= PL_W'(pf_reg) * PL_W'(ff_reg[H-1:0]);
            phi_reg     <= PL_W'(pf_reg) * PL_W'(ff_reg[FF_W-1:H]);
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: sixteen times area squared, divisibility by sixteen
    // ---------------------------------------------------------------
    logic [S16_W-1:0] s16;
    assign s16 = S16_W'(plo_reg) + (S16_W'(phi_reg) << H);

    logic [RAD_W-1:0] rad_m_a_reg, rad_m_b_reg, rad_m_c_reg, rad_area_reg;
    logic [3:0]       flag_s4_reg;   // {area ok, median c, median b, median a}

    always_ff @(posedge clk)
    begin
        if (en) begin
            rad_m_a_reg  <= RAD_W'(mq_a_s3_reg);
            rad_m_b_reg  <= RAD_W'(mq_b_s3_reg);
            rad_m_c_reg  <= RAD_W'(mq_c_s3_reg);
            // a real triangle keeps this quotient below 2^RAD_W
            rad_area_reg <= RAD_W'(s16 >> 4);
            flag_s4_reg  <= {hok_s3_reg && (s16[3:0] == 4'h0), mok_s3_reg};
        end
    end

    // ---------------------------------------------------------------
    // Root stages: four identical root units, flags travel alongside
    // ---------------------------------------------------------------
    logic [ROOT_W-1:0] root_m_a, root_m_b, root_m_c, root_area;
    logic              ex_m_a, ex_m_b, ex_m_c, ex_area;

    ptc_sqrt #(.ROOT_W(ROOT_W), .STEPS(SQRT_STEPS)) u_sqrt_ma (
        .clk(clk), .en(en), .rad(rad_m_a_reg), .root(root_m_a), .exact(ex_m_a)
    );
    ptc_sqrt #(.ROOT_W(ROOT_W), .STEPS(SQRT_STEPS)) u_sqrt_mb (
        .clk(clk), .en(en), .rad(rad_m_b_reg), .root(root_m_b), .exact(ex_m_b)
    );
    ptc_sqrt #(.ROOT_W(ROOT_W), .STEPS(SQRT_STEPS)) u_sqrt_mc (
        .clk(clk), .en(en), .rad(rad_m_c_reg), .root(root_m_c), .exact(ex_m_c)
    );
    ptc_sqrt #(.ROOT_W(ROOT_W), .STEPS(SQRT_STEPS)) u_sqrt_area (
        .clk(clk), .en(en), .rad(rad_area_reg), .root(root_area), .exact(ex_area)
    );

    logic [3:0] flag_reg [NSTG];

    always_ff @(posedge clk)
    begin
        if (en) begin
            flag_reg[0] <= flag_s4_reg;
            for (int i = 1; i < NSTG; i++) begin
                flag_reg[i] <= flag_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage: combine checks, zero the fields of a failed check
    // ---------------------------------------------------------------
    logic    med_all, area_all;
    result_t result_next, result_reg;

    assign med_all  = (&flag_reg[NSTG-1][2:0]) && ex_m_a && ex_m_b && ex_m_c;
    assign area_all = flag_reg[NSTG-1][3] && ex_area;

    always_comb
    begin
        result_next.perfect          = med_all && area_all;
        result_next.medians_integral = med_all;
        result_next.area_integral    = area_all;
        result_next.area             = area_all ? AREA_W'(root_area) : '0;
        result_next.median_a         = med_all ? MED_W'(root_m_a) : '0;
        result_next.median_b         = med_all ? MED_W'(root_m_b) : '0;
        result_next.median_c         = med_all ? MED_W'(root_m_c) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg[LAT-1];

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_perfect_both: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.perfect |-> result.medians_integral && result.area_integral)
        else $error("perfect flag without both checks");

    a_area_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.area_integral |-> result.area == '0)
        else $error("area not zero on failed check");

    a_med_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.medians_integral |->
            result.median_a == '0 && result.median_b == '0 && result.median_c == '0)
        else $error("median not zero on failed check");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg) && $stable(result_reg))
        else $error("pipeline moved while held");

endmodule
